>>> src/epd_pkg.sv
// shared types, widths and constants of the encoder position drive
package epd_pkg;

   // default values of the top level parameters
   localparam int DEF_COUNTS_PER_REV = 330;
   localparam int DEF_FRAC_BITS      = 24;
   localparam int DEF_SUM_WIDTH      = 32;

   // field widths
   localparam int SETPOINT_W = 16;
   localparam int GAIN_W     = 40;
   localparam int GAIN_LO_W  = 20;
   localparam int DUTY_W     = 10;
   localparam int ANGLE_W    = 10;
   localparam int REV_W      = 32;
   localparam int ERR_W      = 18;
   localparam int DIFF_W     = 19;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 40;

   // degrees in one revolution
   localparam int ANGLE_SPAN = 360;

   // command codes
   localparam logic CMD_EDGE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SETPOINT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KP       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KI_T     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KD_T     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND = 3'd6;

   // register reset values
   localparam logic signed [SETPOINT_W-1:0] SETPOINT_RST = 16'sd90;
   localparam logic [GAIN_W-1:0] KP_RST       = 40'd25165824;
   localparam logic [GAIN_W-1:0] KI_T_RST     = 40'd17;
   localparam logic [GAIN_W-1:0] KD_T_RST     = 40'd3355443200;
   localparam logic [DUTY_W-1:0] LIMIT_RST    = 10'd624;
   localparam logic [DUTY_W-1:0] OFFSET_RST   = 10'd210;
   localparam logic [DUTY_W-1:0] DEADBAND_RST = 10'd1;

   // duty values
   localparam logic [DUTY_W-1:0] DUTY_MAX  = 10'd1023;
   localparam logic [DUTY_W-1:0] DUTY_IDLE = 10'd1;

   // per item fields carried alongside the gain pipeline
   typedef struct packed {
      logic                      cmd;
      logic                      forward;
      logic                      enabled;
      logic signed [ANGLE_W-1:0] angle;
      logic signed [REV_W-1:0]   revs;
      logic                      dir;
   } side_type;

   // stage load strobes
   typedef struct packed {
      logic load_s2;
      logic load_s3;
      logic load_s4;
   } pipe_ctl_type;

endpackage

>>> src/epd_req_if.sv
// request channel: encoder edge or control tick
interface epd_req_if;
   logic valid;
   logic ready;
   logic command;
   logic channel_b_level;

   modport source (output valid, output command, output channel_b_level, input ready);
   modport sink   (input valid, input command, input channel_b_level, output ready);
endinterface

>>> src/epd_rsp_if.sv
// response channel: drive outputs and encoder position
interface epd_rsp_if;
   import epd_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [DUTY_W-1:0]         duty;
   logic                      drive_forward;
   logic                      drive_enabled;
   logic signed [ANGLE_W-1:0] angle;
   logic signed [REV_W-1:0]   revolutions;
   logic                      direction;

   modport source (output valid, output duty, output drive_forward, output drive_enabled,
                   output angle, output revolutions, output direction, input ready);
   modport sink   (input valid, input duty, input drive_forward, input drive_enabled,
                   input angle, input revolutions, input direction, output ready);
endinterface

>>> src/epd_encoder.sv
// quadrature edge counter, revolution counter and angle within the revolution
module epd_encoder
   import epd_pkg::*;
#(
   parameter int COUNTS_PER_REV = DEF_COUNTS_PER_REV
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic                      down,
   output logic signed [ANGLE_W-1:0] angle,
   output logic signed [ANGLE_W-1:0] angle_next,
   output logic signed [REV_W-1:0]   revs_next,
   output logic                      dir_next
);

   localparam int MAGN_W = $clog2(COUNTS_PER_REV + 1);
   localparam int CNT_W  = MAGN_W + 1;
   // 2^K >= N^2 keeps the reciprocal exact for every count below N
   localparam int ANG_K  = 2 * MAGN_W + 1;
   localparam int PROD_W = ANG_K + ANGLE_W;
   localparam logic [PROD_W-1:0] ANG_C =
      PROD_W'(((longint'(ANGLE_SPAN) << ANG_K) + COUNTS_PER_REV - 1) / COUNTS_PER_REV);
   localparam logic signed [CNT_W-1:0] CNT_MAX = CNT_W'(COUNTS_PER_REV);

   logic signed [CNT_W-1:0]   cnt_ff, cnt_in, cnt_step;
   logic signed [REV_W-1:0]   rev_ff, rev_in;
   logic signed [ANGLE_W-1:0] angle_ff, angle_in;
   logic                      dir_ff, dir_in;
   logic                      wrap_up, wrap_dn;
   logic [CNT_W-1:0]          cnt_abs;
   logic [PROD_W-1:0]         prod;
   logic [ANGLE_W-1:0]        angle_mag;

   assign cnt_step = down ? cnt_ff - CNT_W'(1) : cnt_ff + CNT_W'(1);
   assign wrap_up  = !down && (cnt_step >= CNT_MAX);
   assign wrap_dn  = down && (cnt_step <= -CNT_MAX);

   always_comb begin
      cnt_in   = cnt_ff;
      rev_in   = rev_ff;
      dir_in   = dir_ff;
      if (step) begin
         dir_in = down;
         cnt_in = (wrap_up || wrap_dn) ? '0 : cnt_step;
         if (wrap_up) begin
            rev_in = rev_ff + REV_W'(1);
         end else if (wrap_dn) begin
            rev_in = rev_ff - REV_W'(1);
         end
      end
   end

   // |count| * 360 / N by a constant reciprocal
   assign cnt_abs   = cnt_in[CNT_W-1] ? unsigned'(-cnt_in) : unsigned'(cnt_in);
   assign prod      = PROD_W'(cnt_abs[MAGN_W-1:0]) * ANG_C;
   assign angle_mag = {1'b0, prod[ANG_K +: ANGLE_W-1]};
   assign angle_in  = step ? (cnt_in[CNT_W-1] ? -signed'(angle_mag) : signed'(angle_mag))
                           : angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         rev_ff   <= '0;
         angle_ff <= '0;
         dir_ff   <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         rev_ff   <= rev_in;
         angle_ff <= angle_in;
         dir_ff   <= dir_in;
      end
   end

   assign angle      = angle_ff;
   assign angle_next = angle_in;
   assign revs_next  = rev_in;
   assign dir_next   = dir_in;

endmodule

>>> src/epd_pid_state.sv
// error, saturating integrator, derivative difference and deadband flags
module epd_pid_state
   import epd_pkg::*;
#(
   parameter int SUM_WIDTH = DEF_SUM_WIDTH,
   parameter int MAG_W     = DEF_SUM_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         tick,
   input  logic signed [SETPOINT_W-1:0] setpoint,
   input  logic [DUTY_W-1:0]            deadband,
   input  logic signed [ANGLE_W-1:0]    angle,
   output logic [MAG_W-1:0]             err_mag,
   output logic                         err_neg,
   output logic [MAG_W-1:0]             sum_mag,
   output logic                         sum_neg,
   output logic [MAG_W-1:0]             diff_mag,
   output logic                         diff_neg,
   output logic                         forward_next,
   output logic                         enabled_next
);

   localparam int SUMX_W = ((SUM_WIDTH > ERR_W) ? SUM_WIDTH : ERR_W) + 1;
   localparam logic signed [SUMX_W-1:0] SUM_MAX =
      SUMX_W'((longint'(1) << (SUM_WIDTH - 1)) - 1);
   localparam logic signed [SUMX_W-1:0] SUM_MIN = -SUM_MAX - SUMX_W'(1);

   logic signed [ERR_W-1:0]     prev_err_ff, err, err_abs, db;
   logic signed [SUM_WIDTH-1:0] sum_ff, sum_in, sum_abs;
   logic signed [SUMX_W-1:0]    sum_x;
   logic signed [DIFF_W-1:0]    diff, diff_abs;
   logic                        forward_ff, enabled_ff, above, below;

   assign err   = ERR_W'(setpoint) - ERR_W'(angle);
   assign sum_x = SUMX_W'(sum_ff) + SUMX_W'(err);
   assign diff  = DIFF_W'(err) - DIFF_W'(prev_err_ff);

   always_comb begin
      priority if (sum_x > SUM_MAX) begin
         sum_in = SUM_WIDTH'(SUM_MAX);
      end else if (sum_x < SUM_MIN) begin
         sum_in = SUM_WIDTH'(SUM_MIN);
      end else begin
         sum_in = SUM_WIDTH'(sum_x);
      end
   end

   assign db    = ERR_W'(signed'({1'b0, deadband}));
   assign above = err > db;
   assign below = err < -db;

   // magnitudes and signs for the gain multipliers
   assign err_abs  = err[ERR_W-1] ? -err : err;
   assign sum_abs  = sum_in[SUM_WIDTH-1] ? -sum_in : sum_in;
   assign diff_abs = diff[DIFF_W-1] ? -diff : diff;
   assign err_mag  = MAG_W'(unsigned'(err_abs));
   assign sum_mag  = MAG_W'(unsigned'(sum_abs));
   assign diff_mag = MAG_W'(unsigned'(diff_abs));
   assign err_neg  = err[ERR_W-1];
   assign sum_neg  = sum_in[SUM_WIDTH-1];
   assign diff_neg = diff[DIFF_W-1];

   assign forward_next = tick ? above : forward_ff;
   assign enabled_next = tick ? (above || below) : enabled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_err_ff <= '0;
         sum_ff      <= '0;
         forward_ff  <= 1'b0;
         enabled_ff  <= 1'b0;
      end else if (tick) begin
         prev_err_ff <= err;
         sum_ff      <= sum_in;
         forward_ff  <= above;
         enabled_ff  <= above || below;
      end
   end

endmodule

>>> src/epd_gain_mult.sv
// gain times magnitude, split into two half-gain products over two stages
module epd_gain_mult
   import epd_pkg::*;
#(
   parameter int MAG_W = DEF_SUM_WIDTH
) (
   input  logic                    clock,
   input  pipe_ctl_type            ctl,
   input  logic [GAIN_W-1:0]       gain,
   input  logic [MAG_W-1:0]        mag,
   input  logic                    neg,
   output logic [GAIN_W+MAG_W-1:0] term_mag,
   output logic                    term_neg
);

   localparam int HI_W   = GAIN_W - GAIN_LO_W;
   localparam int LO_P_W = GAIN_LO_W + MAG_W;
   localparam int HI_P_W = HI_W + MAG_W;
   localparam int TERM_W = GAIN_W + MAG_W;

   logic [LO_P_W-1:0] prod_lo_ff;
   logic [HI_P_W-1:0] prod_hi_ff;
   logic              neg_s2_ff, neg_s3_ff;
   logic [TERM_W-1:0] term_ff, term_in;

   assign term_in = (TERM_W'(prod_hi_ff) << GAIN_LO_W) + TERM_W'(prod_lo_ff);

   always_ff @(posedge clock) begin
      if (ctl.load_s2) begin
         prod_lo_ff <= LO_P_W'(gain[GAIN_LO_W-1:0]) * LO_P_W'(mag);
         prod_hi_ff <= HI_P_W'(gain[GAIN_W-1:GAIN_LO_W]) * HI_P_W'(mag);
         neg_s2_ff  <= neg;
      end
      if (ctl.load_s3) begin
         term_ff   <= term_in;
         neg_s3_ff <= neg_s2_ff;
      end
   end

   assign term_mag = term_ff;
   assign term_neg = neg_s3_ff;

endmodule

>>> src/epd_duty.sv
// pid sum of the three terms, then magnitude, limit and offset to a duty value
module epd_duty
   import epd_pkg::*;
#(
   parameter int FRAC_BITS = DEF_FRAC_BITS,
   parameter int MAG_W     = DEF_SUM_WIDTH
) (
   input  logic                    clock,
   input  pipe_ctl_type            ctl,
   input  logic [GAIN_W+MAG_W-1:0] p_mag,
   input  logic                    p_neg,
   input  logic [GAIN_W+MAG_W-1:0] i_mag,
   input  logic                    i_neg,
   input  logic [GAIN_W+MAG_W-1:0] d_mag,
   input  logic                    d_neg,
   input  logic [DUTY_W-1:0]       duty_limit,
   input  logic [DUTY_W-1:0]       duty_offset,
   output logic [DUTY_W-1:0]       duty
);

   localparam int ACC_W = GAIN_W + MAG_W + 3;

   logic signed [ACC_W-1:0] acc_ff, acc_in, p_s, i_s, d_s;
   logic [ACC_W-1:0]        acc_abs, limit_fx;
   logic [DUTY_W:0]         duty_sum;

   assign p_s    = p_neg ? -signed'(ACC_W'(p_mag)) : signed'(ACC_W'(p_mag));
   assign i_s    = i_neg ? -signed'(ACC_W'(i_mag)) : signed'(ACC_W'(i_mag));
   assign d_s    = d_neg ? -signed'(ACC_W'(d_mag)) : signed'(ACC_W'(d_mag));
   assign acc_in = p_s + i_s + d_s;

   always_ff @(posedge clock) begin
      if (ctl.load_s4) begin
         acc_ff <= acc_in;
      end
   end

   assign acc_abs  = acc_ff[ACC_W-1] ? unsigned'(-acc_ff) : unsigned'(acc_ff);
   assign limit_fx = ACC_W'(duty_limit) << FRAC_BITS;
   assign duty_sum = {1'b0, acc_abs[FRAC_BITS +: DUTY_W]} + {1'b0, duty_offset};

   always_comb begin
      priority if (acc_abs >= limit_fx) begin
         duty = duty_limit;
      end else if (duty_sum[DUTY_W]) begin
         duty = DUTY_MAX;
      end else begin
         duty = duty_sum[DUTY_W-1:0];
      end
   end

endmodule

>>> src/encoder_pid_position_drive.sv
// encoder position counter with a fixed-point pid loop driving pwm duty and direction
//
// each request is an encoder edge (command 0, channel b level picks the count
// direction) or a control tick (command 1) that runs one pid step on setpoint
// minus angle. every request gives exactly one response carrying duty, drive
// pins, angle, revolutions and last direction after that request; an edge
// response repeats the duty and drive pins of the last tick. one request is
// taken per clock unless a stalled response backs up the pipeline. all
// position and integrator state is updated in the transfer cycle, so a request
// may follow the previous one in the next clock. a request passes the operand
// capture stage, the 40-bit gain products, which are built from two half-gain
// products in one stage and combined in the next, the three-term sum and the
// limit and offset stage into the response register. a stalled response lets
// requests keep flowing until the four internal stages are full. the user
// must write registers through the csr port only while no request is in
// flight; the block itself does not enforce this. gains are unsigned with
// FRAC_BITS fraction bits. there is no clearing pass after reset.
module encoder_pid_position_drive
   import epd_pkg::*;
#(
   parameter int COUNTS_PER_REV = DEF_COUNTS_PER_REV,
   parameter int FRAC_BITS      = DEF_FRAC_BITS,
   parameter int SUM_WIDTH      = DEF_SUM_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   epd_req_if.sink               req,
   epd_rsp_if.source             rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // multiplier operand width, wide enough for integrator and difference
   localparam int MAG_W  = (SUM_WIDTH > DIFF_W) ? SUM_WIDTH : DIFF_W;
   localparam int TERM_W = GAIN_W + MAG_W;

   // configuration registers
   logic signed [SETPOINT_W-1:0] setpoint_ff;
   logic [GAIN_W-1:0]            kp_ff, ki_ff, kd_ff;
   logic [DUTY_W-1:0]            limit_ff, offset_ff, deadband_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff <= SETPOINT_RST;
         kp_ff       <= KP_RST;
         ki_ff       <= KI_T_RST;
         kd_ff       <= KD_T_RST;
         limit_ff    <= LIMIT_RST;
         offset_ff   <= OFFSET_RST;
         deadband_ff <= DEADBAND_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SETPOINT: setpoint_ff <= signed'(csr_wdata[SETPOINT_W-1:0]);
            CSR_KP:       kp_ff       <= csr_wdata[GAIN_W-1:0];
            CSR_KI_T:     ki_ff       <= csr_wdata[GAIN_W-1:0];
            CSR_KD_T:     kd_ff       <= csr_wdata[GAIN_W-1:0];
            CSR_LIMIT:    limit_ff    <= csr_wdata[DUTY_W-1:0];
            CSR_OFFSET:   offset_ff   <= csr_wdata[DUTY_W-1:0];
            CSR_DEADBAND: deadband_ff <= csr_wdata[DUTY_W-1:0];
            default: ;  // unused index, write dropped
         endcase
      end
   end

   // pipeline occupancy; a stage takes new data when empty or moving on
   logic         v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic         take1, take2, take3, take4, take5;
   logic         accept, tick, edge_step;
   pipe_ctl_type ctl;

   assign take5 = !rsp_valid_ff || rsp.ready;
   assign take4 = !v4_ff || take5;
   assign take3 = !v3_ff || take4;
   assign take2 = !v2_ff || take3;
   assign take1 = !v1_ff || take2;

   assign req.ready = take1;
   assign accept    = req.valid && take1;
   assign tick      = accept && (req.command == CMD_TICK);
   assign edge_step = accept && (req.command == CMD_EDGE);

   assign ctl.load_s2 = take2;
   assign ctl.load_s3 = take3;
   assign ctl.load_s4 = take4;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take1) v1_ff <= accept;
         if (take2) v2_ff <= v1_ff;
         if (take3) v3_ff <= v2_ff;
         if (take4) v4_ff <= v3_ff;
         if (take5) rsp_valid_ff <= v4_ff;
      end
   end

   // position state, updated on the edge transfer
   logic signed [ANGLE_W-1:0] angle_now, angle_next;
   logic signed [REV_W-1:0]   revs_next;
   logic                      dir_next;

   epd_encoder #(
      .COUNTS_PER_REV (COUNTS_PER_REV)
   ) u_encoder (
      .clock      (clock),
      .reset      (reset),
      .step       (edge_step),
      .down       (req.channel_b_level),
      .angle      (angle_now),
      .angle_next (angle_next),
      .revs_next  (revs_next),
      .dir_next   (dir_next)
   );

   // pid state, updated on the tick transfer
   logic [MAG_W-1:0] err_mag, sum_mag, diff_mag;
   logic             err_neg, sum_neg, diff_neg;
   logic             forward_next, enabled_next;

   epd_pid_state #(
      .SUM_WIDTH (SUM_WIDTH),
      .MAG_W     (MAG_W)
   ) u_pid_state (
      .clock        (clock),
      .reset        (reset),
      .tick         (tick),
      .setpoint     (setpoint_ff),
      .deadband     (deadband_ff),
      .angle        (angle_now),
      .err_mag      (err_mag),
      .err_neg      (err_neg),
      .sum_mag      (sum_mag),
      .sum_neg      (sum_neg),
      .diff_mag     (diff_mag),
      .diff_neg     (diff_neg),
      .forward_next (forward_next),
      .enabled_next (enabled_next)
   );

   // stage 1: operands and per item fields captured on transfer
   side_type         side_in, side1_ff, side2_ff, side3_ff, side4_ff;
   logic [MAG_W-1:0] err_mag_ff, sum_mag_ff, diff_mag_ff;
   logic             err_neg_ff, sum_neg_ff, diff_neg_ff;

   assign side_in.cmd     = req.command;
   assign side_in.forward = forward_next;
   assign side_in.enabled = enabled_next;
   assign side_in.angle   = angle_next;
   assign side_in.revs    = revs_next;
   assign side_in.dir     = dir_next;

   always_ff @(posedge clock) begin
      if (take1) begin
         side1_ff    <= side_in;
         err_mag_ff  <= err_mag;
         err_neg_ff  <= err_neg;
         sum_mag_ff  <= sum_mag;
         sum_neg_ff  <= sum_neg;
         diff_mag_ff <= diff_mag;
         diff_neg_ff <= diff_neg;
      end
      if (take2) side2_ff <= side1_ff;
      if (take3) side3_ff <= side2_ff;
      if (take4) side4_ff <= side3_ff;
   end

   // stages 2 and 3: the three gain products
   logic [TERM_W-1:0] p_mag, i_mag, d_mag;
   logic              p_neg, i_neg, d_neg;

   epd_gain_mult #(.MAG_W (MAG_W)) u_mult_p (
      .clock    (clock),
      .ctl      (ctl),
      .gain     (kp_ff),
      .mag      (err_mag_ff),
      .neg      (err_neg_ff),
      .term_mag (p_mag),
      .term_neg (p_neg)
   );

   epd_gain_mult #(.MAG_W (MAG_W)) u_mult_i (
      .clock    (clock),
      .ctl      (ctl),
      .gain     (ki_ff),
      .mag      (sum_mag_ff),
      .neg      (sum_neg_ff),
      .term_mag (i_mag),
      .term_neg (i_neg)
   );

   epd_gain_mult #(.MAG_W (MAG_W)) u_mult_d (
      .clock    (clock),
      .ctl      (ctl),
      .gain     (kd_ff),
      .mag      (diff_mag_ff),
      .neg      (diff_neg_ff),
      .term_mag (d_mag),
      .term_neg (d_neg)
   );

   // stage 4: pid sum, then duty logic ahead of the response register
   logic [DUTY_W-1:0] duty_calc;

   epd_duty #(
      .FRAC_BITS (FRAC_BITS),
      .MAG_W     (MAG_W)
   ) u_duty (
      .clock       (clock),
      .ctl         (ctl),
      .p_mag       (p_mag),
      .p_neg       (p_neg),
      .i_mag       (i_mag),
      .i_neg       (i_neg),
      .d_mag       (d_mag),
      .d_neg       (d_neg),
      .duty_limit  (limit_ff),
      .duty_offset (offset_ff),
      .duty        (duty_calc)
   );

   // response register; the duty field doubles as the held duty state
   logic [DUTY_W-1:0]         rsp_duty_ff;
   logic                      rsp_forward_ff, rsp_enabled_ff, rsp_dir_ff;
   logic signed [ANGLE_W-1:0] rsp_angle_ff;
   logic signed [REV_W-1:0]   rsp_revs_ff;
   logic                      load_rsp;

   assign load_rsp = take5 && v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_duty_ff <= '0;
      end else if (load_rsp && (side4_ff.cmd == CMD_TICK)) begin
         // inside the deadband the drive idles at duty one
         rsp_duty_ff <= side4_ff.enabled ? duty_calc : DUTY_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_forward_ff <= side4_ff.forward;
         rsp_enabled_ff <= side4_ff.enabled;
         rsp_angle_ff   <= side4_ff.angle;
         rsp_revs_ff    <= side4_ff.revs;
         rsp_dir_ff     <= side4_ff.dir;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.duty          = rsp_duty_ff;
   assign rsp.drive_forward = rsp_forward_ff;
   assign rsp.drive_enabled = rsp_enabled_ff;
   assign rsp.angle         = rsp_angle_ff;
   assign rsp.revolutions   = rsp_revs_ff;
   assign rsp.direction     = rsp_dir_ff;

endmodule

>>> src/epd_checker.sv
// port level checks of the position drive and their bind to the top level
module epd_checker
   import epd_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [DUTY_W-1:0]         rsp_duty,
   input logic signed [ANGLE_W-1:0] rsp_angle,
   input logic signed [REV_W-1:0]   rsp_revs,
   input logic                      rsp_dir
);

   logic signed [REV_W-1:0] last_revs_ff, revs_delta;
   logic                    rsp_xfer;

   assign rsp_xfer   = rsp_valid && rsp_ready;
   assign revs_delta = rsp_revs - last_revs_ff;

   // revolution count of the last delivered response
   always_ff @(posedge clock) begin
      if (reset) begin
         last_revs_ff <= '0;
      end else if (rsp_xfer) begin
         last_revs_ff <= rsp_revs;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_duty) && $stable(rsp_angle)
                                  && $stable(rsp_revs) && $stable(rsp_dir))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_revs_step: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |-> revs_delta == 0 || revs_delta == 1 || revs_delta == -1)
      else $error("revolutions moved by more than one between responses");

   a_revs_wrap: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && revs_delta != 0 |-> rsp_angle == 0 && rsp_dir == (revs_delta == -1))
      else $error("revolution change without cleared angle or matching direction");

endmodule

bind encoder_pid_position_drive epd_checker u_epd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_duty  (rsp.duty),
   .rsp_angle (rsp.angle),
   .rsp_revs  (rsp.revolutions),
   .rsp_dir   (rsp.direction)
);
